// ===== src/chm_pkg.sv =====
package chm_pkg;

   localparam int MaxPoints = 64;
   localparam int CntW      = $clog2(MaxPoints + 1);
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int StkDepth  = MaxPoints + 1;
   localparam int StkAw     = $clog2(StkDepth);
   localparam int StkW      = $clog2(StkDepth + 1);

   // x in the upper half, y in the lower half
   typedef logic [63:0] point_type;

   typedef struct packed {
      logic ins;
      logic shift;
   } chain_ctl_type;

   // order by x, then by y, both signed
   function automatic logic pt_less(input point_type a, input point_type b);
      logic lx, ex, ly;
      lx = $signed(a[63:32]) < $signed(b[63:32]);
      ex = a[63:32] == b[63:32];
      ly = $signed(a[31:0]) < $signed(b[31:0]);
      return lx || (ex && ly);
   endfunction

endpackage

// ===== src/chm_cell.sv =====
module chm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::chain_ctl_type ctl,
   input  chm_pkg::point_type    new_pt,
   input  logic                  left_lt,
   input  chm_pkg::point_type    left_pt,
   input  logic                  left_valid,
   input  chm_pkg::point_type    right_pt,
   input  logic                  right_valid,
   output chm_pkg::point_type    pt,
   output logic                  valid,
   output logic                  lt
);
   import chm_pkg::*;

   point_type pt_ff, pt_in;
   logic      valid_ff, valid_in;

   // new point sorts before this cell (empty cells count as +infinity)
   assign lt    = !valid_ff || pt_less(new_pt, pt_ff);
   assign pt    = pt_ff;
   assign valid = valid_ff;

   always_comb begin
      pt_in    = pt_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         if (left_lt) begin
            pt_in    = left_pt;
            valid_in = left_valid;
         end else if (lt) begin
            pt_in    = new_pt;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         pt_in    = right_pt;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

endmodule

// ===== src/chm_ctrl.sv =====
module chm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_set_last,
   output chm_pkg::chain_ctl_type ctl,
   input  chm_pkg::point_type     head_pt,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_vertex_x,
   output logic signed [31:0]     rsp_vertex_y,
   output logic                   rsp_vertex_last,
   output logic                   rsp_points_dropped
);
   import chm_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_DRAIN = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_TEST  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_CMP   = 3'd5;
   localparam logic [2:0] ST_POPW  = 3'd6;
   localparam logic [2:0] ST_OREAD = 3'd7;
   // output wait shares no code: use a flag
   logic owait_ff, owait_in;

   logic [2:0]       state_ff, state_in;
   logic [CntW-1:0]  cnt_ff, cnt_in, dcnt_ff, dcnt_in, n_ff, n_in;
   logic             ovf_ff, ovf_in, drop_ff, drop_in, phase_ff, phase_in;
   logic [IdxW-1:0]  i_ff, i_in;
   logic [StkW-1:0]  k_ff, k_in, m_ff, m_in, r_ff, r_in, lim;
   point_type        last_ff, last_in, top_ff, top_in, prev_ff, prev_in, q_ff, srd_ff;
   logic signed [32:0] ax_ff, ay_ff, bx_ff, by_ff, ax_in, ay_in, bx_in, by_in;
   logic signed [65:0] p1_ff, p2_ff, p1_in, p2_in;
   logic             pm_we, pm_re, stk_we, stk_re, do_push, vlast;
   logic [StkAw-1:0] stk_ra;

   point_type pm_mem  [MaxPoints];
   point_type stk_mem [StkDepth];

   assign lim   = phase_ff ? m_ff : StkW'(1);
   assign vlast = r_ff == (k_ff - StkW'(1));

   always_comb begin
      state_in = state_ff;
      owait_in = owait_ff;
      cnt_in   = cnt_ff;
      dcnt_in  = dcnt_ff;
      n_in     = n_ff;
      ovf_in   = ovf_ff;
      drop_in  = drop_ff;
      phase_in = phase_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      last_in  = last_ff;
      top_in   = top_ff;
      prev_in  = prev_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      ctl      = '0;
      pm_we    = 1'b0;
      pm_re    = 1'b0;
      stk_we   = 1'b0;
      stk_re   = 1'b0;
      stk_ra   = '0;
      do_push  = 1'b0;

      if (owait_ff) begin
         if (!rsp_stall) begin
            owait_in = 1'b0;
            if (vlast) begin
               state_in = ST_LOAD;
            end else begin
               r_in     = r_ff + StkW'(1);
               state_in = ST_OREAD;
            end
         end
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  if (cnt_ff < CntW'(MaxPoints)) begin
                     ctl.ins = 1'b1;
                     cnt_in  = cnt_ff + CntW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_set_last) begin
                     drop_in  = ovf_in;
                     dcnt_in  = cnt_in;
                     n_in     = '0;
                     cnt_in   = '0;
                     ovf_in   = 1'b0;
                     state_in = ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (dcnt_ff == '0) begin
                  k_in     = '0;
                  i_in     = '0;
                  phase_in = 1'b0;
                  state_in = ST_FETCH;
               end else begin
                  ctl.shift = 1'b1;
                  dcnt_in   = dcnt_ff - CntW'(1);
                  if (n_ff == '0 || head_pt != last_ff) begin
                     pm_we   = 1'b1;
                     last_in = head_pt;
                     n_in    = n_ff + CntW'(1);
                  end
               end
            end
            ST_FETCH: begin
               pm_re    = 1'b1;
               state_in = ST_TEST;
            end
            ST_TEST: begin
               if (n_ff >= CntW'(3) && k_ff > lim) begin
                  ax_in    = 33'(signed'(top_ff[63:32])) - 33'(signed'(prev_ff[63:32]));
                  ay_in    = 33'(signed'(top_ff[31:0]))  - 33'(signed'(prev_ff[31:0]));
                  bx_in    = 33'(signed'(top_ff[63:32])) - 33'(signed'(q_ff[63:32]));
                  by_in    = 33'(signed'(top_ff[31:0]))  - 33'(signed'(q_ff[31:0]));
                  state_in = ST_MUL;
               end else begin
                  do_push = 1'b1;
               end
            end
            ST_MUL: begin
               p1_in    = 66'(ax_ff) * 66'(by_ff);
               p2_in    = 66'(ay_ff) * 66'(bx_ff);
               state_in = ST_CMP;
            end
            ST_CMP: begin
               // non-negative cross product: left turn missing, pop the top
               if (p1_ff >= p2_ff) begin
                  k_in     = k_ff - StkW'(1);
                  top_in   = prev_ff;
                  stk_re   = 1'b1;
                  stk_ra   = (k_ff >= StkW'(3)) ? StkAw'(k_ff - StkW'(3)) : '0;
                  state_in = ST_POPW;
               end else begin
                  do_push = 1'b1;
               end
            end
            ST_POPW: begin
               prev_in  = srd_ff;
               state_in = ST_TEST;
            end
            ST_OREAD: begin
               stk_re   = 1'b1;
               stk_ra   = StkAw'(r_ff);
               owait_in = 1'b1;
            end
            default: begin
               state_in = ST_LOAD;
            end
         endcase
      end

      if (do_push) begin
         stk_we  = 1'b1;
         prev_in = top_ff;
         top_in  = q_ff;
         k_in    = k_ff + StkW'(1);
         state_in = ST_FETCH;
         if (!phase_ff) begin
            if (i_ff == IdxW'(n_ff - CntW'(1))) begin
               if (n_ff < CntW'(3)) begin
                  r_in     = '0;
                  state_in = ST_OREAD;
               end else begin
                  phase_in = 1'b1;
                  m_in     = k_ff + StkW'(1);
                  i_in     = IdxW'(n_ff - CntW'(2));
               end
            end else begin
               i_in = i_ff + IdxW'(1);
            end
         end else if (i_ff == '0) begin
            // closing push repeats the start vertex; drop it
            k_in     = k_ff;
            r_in     = '0;
            state_in = ST_OREAD;
         end else begin
            i_in = i_ff - IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         owait_ff <= 1'b0;
         cnt_ff   <= '0;
         dcnt_ff  <= '0;
         n_ff     <= '0;
         ovf_ff   <= 1'b0;
         drop_ff  <= 1'b0;
         phase_ff <= 1'b0;
         i_ff     <= '0;
         k_ff     <= '0;
         m_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         owait_ff <= owait_in;
         cnt_ff   <= cnt_in;
         dcnt_ff  <= dcnt_in;
         n_ff     <= n_in;
         ovf_ff   <= ovf_in;
         drop_ff  <= drop_in;
         phase_ff <= phase_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         m_ff     <= m_in;
         r_ff     <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      top_ff  <= top_in;
      prev_ff <= prev_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
   end

   // sorted, de-duplicated points
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[n_ff[IdxW-1:0]] <= head_pt;
      end
      if (pm_re) begin
         q_ff <= pm_mem[i_ff];
      end
   end

   // hull stack, holds the vertex points themselves
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[k_ff[StkAw-1:0]] <= q_ff;
      end
      if (stk_re) begin
         srd_ff <= stk_mem[stk_ra];
      end
   end

   assign req_stall          = (state_ff != ST_LOAD) || owait_ff;
   assign rsp_valid          = owait_ff;
   assign rsp_vertex_x       = signed'(srd_ff[63:32]);
   assign rsp_vertex_y       = signed'(srd_ff[31:0]);
   assign rsp_vertex_last    = vlast;
   assign rsp_points_dropped = drop_ff;

endmodule

// ===== src/convex_hull_monotone_chain.sv =====
// Convex hull engine (monotone chain). Points enter one request per cycle while loading and are
// sorted on arrival by a row of insertion cells. The request with set_last closes the set.
// The row then drains into a point memory, and duplicates are dropped on the way. Each push
// of the lower and upper hulls goes through fetch and test. A push that follows an orientation
// test also goes through multiply and compare. Each pop goes through difference, multiply,
// compare and stack reload. Vertices go out counterclockwise from the smallest point; each
// is read from the stack and then held until the receiver takes it. No request is taken from
// set end until the last vertex is taken. Points past the store capacity are discarded and
// flagged in points_dropped.
module convex_hull_monotone_chain (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic               req_set_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic               rsp_vertex_last,
   output logic               rsp_points_dropped
);
   import chm_pkg::*;

   chain_ctl_type ctl;
   point_type     new_pt;
   point_type     cell_pt    [MaxPoints];
   logic          cell_valid [MaxPoints];
   logic          cell_lt    [MaxPoints];

   assign new_pt = {req_point_x, req_point_y};

   // sorted row: cell 0 holds the smallest point
   genvar g;
   generate
      for (g = 0; g < MaxPoints; g++) begin : g_cell
         point_type l_pt, r_pt;
         logic      l_lt, l_valid, r_valid;
         if (g == 0) begin : g_head
            assign l_pt    = '0;
            assign l_lt    = 1'b0;
            assign l_valid = 1'b0;
         end else begin : g_mid
            assign l_pt    = cell_pt[g-1];
            assign l_lt    = cell_lt[g-1];
            assign l_valid = cell_valid[g-1];
         end
         if (g == MaxPoints - 1) begin : g_tail
            assign r_pt    = '0;
            assign r_valid = 1'b0;
         end else begin : g_body
            assign r_pt    = cell_pt[g+1];
            assign r_valid = cell_valid[g+1];
         end
         chm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_pt      (new_pt),
            .left_lt     (l_lt),
            .left_pt     (l_pt),
            .left_valid  (l_valid),
            .right_pt    (r_pt),
            .right_valid (r_valid),
            .pt          (cell_pt[g]),
            .valid       (cell_valid[g]),
            .lt          (cell_lt[g])
         );
      end
   endgenerate

   chm_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_set_last       (req_set_last),
      .ctl                (ctl),
      .head_pt            (cell_pt[0]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_vertex_x       (rsp_vertex_x),
      .rsp_vertex_y       (rsp_vertex_y),
      .rsp_vertex_last    (rsp_vertex_last),
      .rsp_points_dropped (rsp_points_dropped)
   );

endmodule
